[rtl/american_option_binomial_pricer_macros.svh]
// assertion macros for the binomial pricer
`ifndef AMERICAN_OPTION_BINOMIAL_PRICER_MACROS_SVH
`define AMERICAN_OPTION_BINOMIAL_PRICER_MACROS_SVH

// condition holds at every edge out of reset
`define AOBP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define AOBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/aobp_pkg.sv]
package aobp_pkg;

  localparam int unsigned DefMaxLevels = 1024;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned LevelCountW  = 11;

  localparam logic [CfgIdxW-1:0] REG_UP_FACTOR     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DOWN_FACTOR   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_UP_PROB       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_STEP_DISCOUNT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OPTION_KIND   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_COUNT   = 3'd5;

  localparam logic KIND_CALL = 1'b0;

  typedef struct packed {
    logic [31:0] up_factor;
    logic [31:0] down_factor;
    logic [31:0] up_probability;
    logic [31:0] step_discount;
    logic        option_kind;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_SPOT,
    OP_MUL_PF,
    OP_ROUND_P,
    OP_WRITE_LEAF,
    OP_READ0,
    OP_PRIME,
    OP_READ,
    OP_LOAD,
    OP_MUL_UP,
    OP_MUL_DN,
    OP_SUM,
    OP_MUL_DISC,
    OP_WRITE_NODE,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   fac_up;
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEAF_START,
    ST_LEAF_MUL,
    ST_LEAF_RND,
    ST_LEAF_WR,
    ST_LVL_RD0,
    ST_LVL_PRIME,
    ST_NODE_RD,
    ST_NODE_LD,
    ST_NODE_MPF,
    ST_NODE_RND,
    ST_NODE_MUP,
    ST_NODE_MDN,
    ST_NODE_SUM,
    ST_NODE_MDS,
    ST_NODE_WR,
    ST_DONE
  } ctl_state_t;

  function automatic logic [31:0] payoff(input logic [31:0] price, input logic [31:0] strike,
                                         input logic kind);
    logic [31:0] r;
    if (kind == KIND_CALL) begin
      r = (price > strike) ? price - strike : 32'd0;
    end else begin
      r = (strike > price) ? strike - price : 32'd0;
    end
    return r;
  endfunction

endpackage

[rtl/aobp_datapath.sv]
module aobp_datapath #(
  parameter int unsigned MAX_LEVELS = aobp_pkg::DefMaxLevels,
  parameter int unsigned IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
  input  logic             clk,
  input  aobp_pkg::dp_cmd_t cmd,
  input  aobp_pkg::cfg_t   cfg,
  input  logic [IW-1:0]    node_index,
  input  logic [31:0]      spot_price,
  input  logic [31:0]      strike_price,
  output logic [31:0]      option_value,
  output logic             saturated
);
  import aobp_pkg::*;

  logic [31:0] node_values [MAX_LEVELS];
  logic [31:0] node_prices [MAX_LEVELS];

  logic [31:0] spot, strike, price, vup, vdown, e, last_v, rdv, rdp;
  logic [64:0] prod;
  logic [63:0] acc;
  logic        sat;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [34:0] rounded;
  logic [64:0] sum_full, disc_full;
  logic [31:0] exer, node_v;
  logic [IW-1:0] rd_v_addr;
  logic        v_we, p_we;
  logic [31:0] v_wd;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_PF: begin
        mul_a = {1'b0, cmd.fac_up ? cfg.up_factor : cfg.down_factor};
        mul_b = price;
      end
      OP_MUL_UP: begin
        mul_a = {1'b0, cfg.up_probability};
        mul_b = vup;
      end
      OP_MUL_DN: begin
        mul_a = 33'h1_0000_0000 - {1'b0, cfg.up_probability};
        mul_b = vdown;
      end
      OP_MUL_DISC: begin
        mul_a = {1'b0, cfg.step_discount};
        mul_b = e;
      end
      default: ;
    endcase
  end

  assign rounded   = 35'((prod + 65'(1 << 29)) >> 30);
  assign sum_full  = {1'b0, acc} + prod + 65'(64'd1 << 31);
  assign disc_full = prod + 65'(64'd1 << 31);
  assign exer      = payoff(price, strike, cfg.option_kind);
  assign node_v    = (disc_full[63:32] > exer) ? disc_full[63:32] : exer;
  assign rd_v_addr = (cmd.op == OP_READ0) ? node_index : node_index + IW'(1);
  assign v_we      = (cmd.op == OP_WRITE_LEAF) || (cmd.op == OP_WRITE_NODE);
  assign p_we      = v_we;
  assign v_wd      = (cmd.op == OP_WRITE_LEAF) ? exer : node_v;

  // node stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (v_we) begin
      node_values[node_index] <= v_wd;
    end
    rdv <= node_values[rd_v_addr];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      node_prices[node_index] <= price;
    end
    rdp <= node_prices[node_index];
  end

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_CAPTURE: begin
        spot   <= spot_price;
        strike <= strike_price;
        sat    <= 1'b0;
      end
      OP_LOAD_SPOT: price <= spot;
      OP_MUL_PF, OP_MUL_UP, OP_MUL_DISC: prod <= 65'(mul_a * mul_b);
      OP_MUL_DN: begin
        acc  <= prod[63:0];
        prod <= 65'(mul_a * mul_b);
      end
      OP_ROUND_P: begin
        if (rounded[34:32] != 3'd0) begin
          price <= 32'hFFFF_FFFF;
          sat   <= 1'b1;
        end else begin
          price <= rounded[31:0];
        end
      end
      OP_WRITE_LEAF: last_v <= exer;
      OP_PRIME:      vup    <= rdv;
      OP_LOAD: begin
        vdown <= vup;
        vup   <= rdv;
        price <= rdp;
      end
      OP_SUM:        e      <= sum_full[63:32];
      OP_WRITE_NODE: last_v <= node_v;
      OP_OUT: begin
        option_value <= last_v;
        saturated    <= sat;
      end
      default: ;
    endcase
  end

endmodule

[rtl/aobp_controller.sv]
module aobp_controller #(
  parameter int unsigned MAX_LEVELS = aobp_pkg::DefMaxLevels,
  parameter int unsigned IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
  parameter int unsigned LW = $clog2(MAX_LEVELS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LW-1:0]     levels,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output aobp_pkg::dp_cmd_t cmd,
  output logic [IW-1:0]     node_index
);
  import aobp_pkg::*;

  ctl_state_t state, state_next;
  logic [LW-1:0] j, k, i;
  logic [LW:0]   last_idx, jk_sum, k_inc;
  logic          out_free, leaf_last, mul_last, level_last;

  assign last_idx   = (LW+1)'(levels) - (LW+1)'(1);
  assign jk_sum     = (LW+1)'(j) + (LW+1)'(k);
  assign k_inc      = (LW+1)'(k) + (LW+1)'(1);
  assign leaf_last  = (LW+1)'(j) == last_idx;
  assign mul_last   = k_inc == last_idx;
  assign level_last = (LW+1)'(j) + (LW+1)'(1) == (LW+1)'(i);
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE);
  assign node_index = j[IW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_valid) state_next = ST_LEAF_START;
      ST_LEAF_START: state_next = (last_idx == '0) ? ST_LEAF_WR : ST_LEAF_MUL;
      ST_LEAF_MUL:   state_next = ST_LEAF_RND;
      ST_LEAF_RND:   state_next = mul_last ? ST_LEAF_WR : ST_LEAF_MUL;
      ST_LEAF_WR: begin
        if (!leaf_last)           state_next = ST_LEAF_START;
        else if (last_idx == '0)  state_next = ST_DONE;
        else                      state_next = ST_LVL_RD0;
      end
      ST_LVL_RD0:    state_next = ST_LVL_PRIME;
      ST_LVL_PRIME:  state_next = ST_NODE_RD;
      ST_NODE_RD:    state_next = ST_NODE_LD;
      ST_NODE_LD:    state_next = ST_NODE_MPF;
      ST_NODE_MPF:   state_next = ST_NODE_RND;
      ST_NODE_RND:   state_next = ST_NODE_MUP;
      ST_NODE_MUP:   state_next = ST_NODE_MDN;
      ST_NODE_MDN:   state_next = ST_NODE_SUM;
      ST_NODE_SUM:   state_next = ST_NODE_MDS;
      ST_NODE_MDS:   state_next = ST_NODE_WR;
      ST_NODE_WR: begin
        if (!level_last)          state_next = ST_NODE_RD;
        else if (i == LW'(1))     state_next = ST_DONE;
        else                      state_next = ST_LVL_RD0;
      end
      ST_DONE:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.fac_up = 1'b1;
    unique case (state)
      ST_IDLE:       cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
      ST_LEAF_START: cmd.op = OP_LOAD_SPOT;
      ST_LEAF_MUL: begin
        cmd.op     = OP_MUL_PF;
        cmd.fac_up = (jk_sum >= last_idx);
      end
      ST_LEAF_RND:   cmd.op = OP_ROUND_P;
      ST_LEAF_WR:    cmd.op = OP_WRITE_LEAF;
      ST_LVL_RD0:    cmd.op = OP_READ0;
      ST_LVL_PRIME:  cmd.op = OP_PRIME;
      ST_NODE_RD:    cmd.op = OP_READ;
      ST_NODE_LD:    cmd.op = OP_LOAD;
      ST_NODE_MPF:   cmd.op = OP_MUL_PF;
      ST_NODE_RND:   cmd.op = OP_ROUND_P;
      ST_NODE_MUP:   cmd.op = OP_MUL_UP;
      ST_NODE_MDN:   cmd.op = OP_MUL_DN;
      ST_NODE_SUM:   cmd.op = OP_SUM;
      ST_NODE_MDS:   cmd.op = OP_MUL_DISC;
      ST_NODE_WR:    cmd.op = OP_WRITE_NODE;
      ST_DONE:       cmd.op = out_free ? OP_OUT : OP_NONE;
      default:       cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      j         <= '0;
      k         <= '0;
      i         <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:       j <= '0;
        ST_LEAF_START: k <= '0;
        ST_LEAF_RND:   k <= k_inc[LW-1:0];
        ST_LEAF_WR: begin
          if (leaf_last) begin
            j <= '0;
            i <= last_idx[LW-1:0];
          end else begin
            j <= j + LW'(1);
          end
        end
        ST_NODE_WR: begin
          if (level_last) begin
            j <= '0;
            i <= i - LW'(1);
          end else begin
            j <= j + LW'(1);
          end
        end
        ST_DONE: if (out_free) out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/american_option_binomial_pricer.sv]
// American call or put pricer on a recombining binomial lattice. Program the move
// factors (Q2.30), the up probability and step discount (Q0.32), the payoff kind and
// the level count L through the write port while idle, then send one spot/strike pair
// (Q16.16) per request; one root value comes back with a flag set if any node price
// saturated. One request is worked at a time, with one shared multiplier driven by a
// sequencer: first the leaves are built (each leaf restarts from the spot and walks
// L-1 rounded products), then the backward pass works through every interior node,
// level by level. The result sits in an output register, so a finished result may
// wait for its transfer while the next request is taken.
module american_option_binomial_pricer #(
  parameter int unsigned MAX_LEVELS = aobp_pkg::DefMaxLevels
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [aobp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [aobp_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       spot_price,
  input  logic [31:0]                       strike_price,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [31:0]                       option_value,
  output logic                              saturated
);
  import aobp_pkg::*;
  `include "american_option_binomial_pricer_macros.svh"

  localparam int unsigned IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);

  cfg_t                   cfg;
  logic [LevelCountW-1:0] level_count;
  logic [LW-1:0]          levels;
  dp_cmd_t                cmd;
  logic [IW-1:0]          node_index;

  // configuration registers, writes land at once
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.up_factor      <= 32'h4000_0000;
      cfg.down_factor    <= 32'h4000_0000;
      cfg.up_probability <= 32'h8000_0000;
      cfg.step_discount  <= 32'hFFFF_FFFF;
      cfg.option_kind    <= KIND_CALL;
      level_count        <= 11'd1024;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_UP_FACTOR:     cfg.up_factor      <= cfg_data;
        REG_DOWN_FACTOR:   cfg.down_factor    <= cfg_data;
        REG_UP_PROB:       cfg.up_probability <= cfg_data;
        REG_STEP_DISCOUNT: cfg.step_discount  <= cfg_data;
        REG_OPTION_KIND:   cfg.option_kind    <= cfg_data[0];
        REG_LEVEL_COUNT:   level_count        <= cfg_data[LevelCountW-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // zero levels behaves as one, anything past the store depth is clipped
  always_comb begin
    if (level_count == '0) begin
      levels = LW'(1);
    end else if (32'(level_count) > MAX_LEVELS) begin
      levels = LW'(MAX_LEVELS);
    end else begin
      levels = LW'(level_count);
    end
  end

  // sequencer: leaf build, then backward induction
  aobp_controller #(
    .MAX_LEVELS (MAX_LEVELS),
    .IW         (IW),
    .LW         (LW)
  ) u_ctl (
    .clk        (clk),
    .rst        (rst),
    .levels     (levels),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .node_index (node_index)
  );

  // shared multiplier, node stores and result register
  aobp_datapath #(
    .MAX_LEVELS (MAX_LEVELS),
    .IW         (IW)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .cfg          (cfg),
    .node_index   (node_index),
    .spot_price   (spot_price),
    .strike_price (strike_price),
    .option_value (option_value),
    .saturated    (saturated)
  );

  // a request transfer starts work, so the input side closes
  `AOBP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open while busy")
  // the clipped level count always lies within the store
  `AOBP_ASSERT_ALWAYS(a_levels_range, levels != '0 && 32'(levels) <= MAX_LEVELS, "levels out of range")
  // a capture is only issued on a request transfer
  `AOBP_ASSERT_ALWAYS(a_capture_on_xfer, (cmd.op != OP_CAPTURE) || (in_valid && in_ready), "stray capture")
  // the result register is loaded only when it is free
  `AOBP_ASSERT_ALWAYS(a_out_free, (cmd.op != OP_OUT) || !out_valid || out_ready, "result overwritten")

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aobp_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 3'd7;
  localparam int unsigned        LATTICE_MAX  = 1024;
  localparam logic [31:0]        ONE_Q30      = 32'h4000_0000;

  typedef struct {
    logic [31:0] spot;
    logic [31:0] strike;
  } quote_t;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } price_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         spot_price;
  logic [31:0]         strike_price;
  logic                out_valid;
  logic                out_ready;
  logic [31:0]         option_value;
  logic                saturated;

  american_option_binomial_pricer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .spot_price   (spot_price),
    .strike_price (strike_price),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .option_value (option_value),
    .saturated    (saturated)
  );

  // local copy of the pricing registers
  logic [31:0] m_up;
  logic [31:0] m_down;
  logic [31:0] m_prob;
  logic [31:0] m_disc;
  logic        m_kind;
  logic [10:0] m_levels;

  quote_t quotes_pending[$];
  price_t prices_due[$];

  int unsigned mismatches;
  int unsigned quotes_sent;
  int unsigned prices_checked;
  int unsigned sat_seen;
  bit          no_gaps;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_cnt;
  int unsigned tx_gap;
  int unsigned rx_gap;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // price times factor, rounded, saturating
  function automatic logic [31:0] scale(input logic [31:0] p, input logic [31:0] f,
                                        inout logic sat);
    logic [63:0] t;
    t = ({32'd0, p} * {32'd0, f} + 64'h2000_0000) >> 30;
    if (t > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return t[31:0];
  endfunction

  function automatic logic [31:0] exercise(input logic [31:0] p, input logic [31:0] k);
    if (m_kind == KIND_CALL) return (p > k) ? p - k : 32'd0;
    return (k > p) ? k - p : 32'd0;
  endfunction

  function automatic logic [31:0] discounted_mean(input logic [31:0] vu, input logic [31:0] vd);
    logic [63:0] wu;
    logic [63:0] wd;
    logic [63:0] e;
    wu = {32'd0, m_prob};
    wd = 64'h1_0000_0000 - wu;
    e  = (wu * vu + wd * vd + 64'h8000_0000) >> 32;
    e  = (e * {32'd0, m_disc} + 64'h8000_0000) >> 32;
    return e[31:0];
  endfunction

  // backward induction over the lattice, american exercise at every node
  function automatic price_t price_american(input quote_t q);
    logic [31:0] vals[LATTICE_MAX];
    logic [31:0] prcs[LATTICE_MAX];
    logic [31:0] p;
    logic [31:0] e;
    logic [31:0] x;
    logic        sat;
    int unsigned n;
    price_t      r;
    sat = 1'b0;
    n = m_levels;
    if (n < 1) n = 1;
    if (n > LATTICE_MAX) n = LATTICE_MAX;
    for (int unsigned j = 0; j < n; j++) begin
      p = q.spot;
      for (int unsigned k = 0; k < n - 1 - j; k++) p = scale(p, m_down, sat);
      for (int unsigned k = 0; k < j; k++) p = scale(p, m_up, sat);
      prcs[j] = p;
      vals[j] = exercise(p, q.strike);
    end
    for (int unsigned i = n - 1; i > 0; i--) begin
      for (int unsigned j = 0; j < i; j++) begin
        e = discounted_mean(vals[j+1], vals[j]);
        p = scale(prcs[j], m_up, sat);
        x = exercise(p, q.strike);
        prcs[j] = p;
        vals[j] = (e > x) ? e : x;
      end
    end
    r.value = vals[0];
    r.sat   = sat;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: feeds quotes from the pending queue, predicts on each transfer
  always @(posedge clk) begin
    quote_t q;
    if (rst) begin
      in_valid     <= 1'b0;
      spot_price   <= '0;
      strike_price <= '0;
      tx_gap       <= 0;
    end else begin
      if (in_valid && in_ready) begin
        q.spot   = spot_price;
        q.strike = strike_price;
        prices_due.push_back(price_american(q));
        quotes_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the offer unchanged
      end else if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (quotes_pending.size() > 0) begin
        q = quotes_pending.pop_front();
        in_valid     <= 1'b1;
        spot_price   <= q.spot;
        strike_price <= q.strike;
        tx_gap       <= no_gaps ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, field-wise check
  always @(posedge clk) begin
    price_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (prices_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h sat %b", option_value, saturated);
        end else begin
          want = prices_due.pop_front();
          prices_checked++;
          if (saturated) sat_seen++;
          if (option_value !== want.value || saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: value exp %h got %h, sat exp %b got %b",
                       want.value, option_value, want.sat, saturated);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt  <= 4000;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap    <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_gap    <= no_gaps ? 0 : pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_UP_FACTOR:     m_up     = val;
      REG_DOWN_FACTOR:   m_down   = val;
      REG_UP_PROB:       m_prob   = val;
      REG_STEP_DISCOUNT: m_disc   = val;
      REG_OPTION_KIND:   m_kind   = val[0];
      REG_LEVEL_COUNT:   m_levels = val[10:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] u, input logic [31:0] d,
                               input logic [31:0] p, input logic [31:0] disc,
                               input logic kind, input logic [10:0] lv);
    write_reg(REG_UP_FACTOR, u);
    write_reg(REG_DOWN_FACTOR, d);
    write_reg(REG_UP_PROB, p);
    write_reg(REG_STEP_DISCOUNT, disc);
    write_reg(REG_OPTION_KIND, {31'd0, kind});
    write_reg(REG_LEVEL_COUNT, {21'd0, lv});
  endtask

  // every quote sent and every price back before registers move
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (quotes_pending.size() > 0 || in_valid || prices_due.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_quote(input logic [31:0] s, input logic [31:0] k);
    quote_t q;
    q.spot   = s;
    q.strike = k;
    quotes_pending.push_back(q);
  endtask

  // up factor a little above one, down factor its reciprocal
  task automatic random_setting(input int unsigned lv_max);
    logic [31:0] u;
    logic [63:0] d;
    u = $urandom_range(ONE_Q30, ONE_Q30 + 32'h1000_0000);
    d = (64'h1000_0000_0000_0000 + u / 2) / u;
    apply_setting(u, d[31:0], $urandom, $urandom_range(32'hF000_0000, 32'hFFFF_FFFF),
                  1'($urandom_range(0, 1)), 11'($urandom_range(0, lv_max)));
  endtask

  initial begin
    logic [31:0] s;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    quotes_sent  = 0;
    prices_checked = 0;
    sat_seen     = 0;
    no_gaps      = 1'b0;
    hold_req     = 1'b0;
    m_up = ONE_Q30; m_down = ONE_Q30; m_prob = 32'h8000_0000;
    m_disc = 32'hFFFF_FFFF; m_kind = KIND_CALL; m_levels = 11'd1024;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero levels behaves as one: payoff at spot, field extremes
    apply_setting(32'h4666_6666, 32'h3A2E_8BA3, 32'h8000_0000, 32'hFFF0_0000, 1'b0, 11'd0);
    add_quote(32'd0, 32'd0);
    add_quote(32'hFFFF_FFFF, 32'd0);
    add_quote(32'd0, 32'hFFFF_FFFF);
    add_quote(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // single level, put, plus a write to an unmapped index that must change nothing
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    apply_setting(32'h4666_6666, 32'h3A2E_8BA3, 32'h8000_0000, 32'hFFF0_0000, 1'b1, 11'd1);
    write_reg(REG_UNMAPPED, 32'd0);
    add_quote(32'd0, 32'hFFFF_FFFF);
    add_quote(32'hFFFF_FFFF, 32'd0);
    add_quote(32'h0001_0000, 32'h0002_0000);
    add_quote(32'h0002_0000, 32'h0001_0000);
    wait_idle();

    // all factor registers at full scale: prices saturate
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 11'd4);
    add_quote(32'hFFFF_FFFF, 32'd0);
    add_quote(32'h0001_0000, 32'h0001_0000);
    add_quote(32'h4000_0000, 32'h0000_0001);
    wait_idle();

    // all factor registers at zero: prices collapse, expectation vanishes
    apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 11'd3);
    add_quote(32'h1234_5678, 32'h8765_4321);
    add_quote(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_quote(32'd0, 32'h0000_0001);
    wait_idle();

    // unit factors, even odds, two levels
    apply_setting(ONE_Q30, ONE_Q30, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 11'd2);
    add_quote(32'h0064_0000, 32'h005A_0000);
    add_quote(32'h0064_0000, 32'h006E_0000);
    add_quote(32'hAAAA_AAAA, 32'h5555_5555);
    add_quote(32'h5555_5555, 32'hAAAA_AAAA);
    wait_idle();

    // random settings with small lattices; one phase without gaps, one with a long stall
    for (int ph = 0; ph < 9; ph++) begin
      random_setting(12);
      no_gaps = (ph == 3);
      for (int n = 0; n < 11; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_quote($urandom, $urandom);
        end else begin
          s = $urandom_range(32'h0000_1000, 32'h0100_0000);
          add_quote(s, s + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
        end
      end
      if (ph == 5) hold_req = 1'b1;
      wait_idle();
    end
    no_gaps = 1'b0;

    // one request at the deepest lattice, level count above the limit
    random_setting(0);
    write_reg(REG_LEVEL_COUNT, 32'h0000_07FF);
    add_quote(32'h0064_0000, 32'h0064_0000);
    wait_idle();

    repeat (50) @(posedge clk);
    $display("priced %0d quotes over 15 register settings, %0d results checked, %0d saturated",
             quotes_sent, prices_checked, sat_seen);
    $display("lattice depths from one level to the full limit, calls and puts, long output stall");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, allows for the deepest lattice several times over
  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
